// File: hw/rtl/timed_packet_hold_queue_core_macros.svh
// assertion macros for the timed packet hold queue
`ifndef TIMED_PACKET_HOLD_QUEUE_CORE_MACROS_SVH
`define TIMED_PACKET_HOLD_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH

`define TPHQ_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("tphq invariant violated");

`define TPHQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tphq implication violated");

`define TPHQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tphq next-cycle check violated");

`else

`define TPHQ_ASSERT_ALWAYS(label, clk, rstn, cond)
`define TPHQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TPHQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/tphq_pkg.sv
// shared types and constants of the timed packet hold queue
package tphq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int REQ_W  = 3;
    localparam int DST_W  = 32;
    localparam int HND_W  = 16;
    localparam int POS_W  = 5;
    localparam int TIME_W = 32;
    localparam int STAT_W = 4;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // input tdata field offsets
    localparam int IN_REQ_LSB = 0;
    localparam int IN_DST_LSB = IN_REQ_LSB + REQ_W;
    localparam int IN_HND_LSB = IN_DST_LSB + DST_W;
    localparam int IN_POS_LSB = IN_HND_LSB + HND_W;
    localparam int IN_NOW_LSB = IN_POS_LSB + POS_W;
    localparam int IN_W       = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    localparam int OUT_W       = STAT_W + HND_W + DST_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = TIME_W;
    localparam logic [CFG_AW-1:0] CFG_HOLD_TIMEOUT  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_RETRY_TIMEOUT = 1'b1;
    localparam logic [TIME_W-1:0] HOLD_TIMEOUT_RST  = 32'd1000;
    localparam logic [TIME_W-1:0] RETRY_TIMEOUT_RST = 32'd100;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ      = 3'd0,
        REQ_DEQ_HEAD = 3'd1,
        REQ_DEQ_DST  = 3'd2,
        REQ_PURGE    = 3'd3,
        REQ_RETRY    = 3'd4,
        REQ_PEEK     = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ENQUEUED     = 4'd0,
        ST_DROP_FULL    = 4'd1,
        ST_DROP_TIMEOUT = 4'd2,
        ST_DEQUEUED     = 4'd3,
        ST_EMPTY        = 4'd4,
        ST_PURGED       = 4'd5,
        ST_PURGE_DONE   = 4'd6,
        ST_RENEWED      = 4'd7,
        ST_NOT_DUE      = 4'd8,
        ST_BAD_POS      = 4'd9,
        ST_PEEKED       = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FINISH,
        S_POS_RD,
        S_POS_EV
    } state_t;

    typedef struct packed {
        logic [DST_W-1:0]  dst;
        logic [HND_W-1:0]  handle;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] retry_due;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic direct_init;
        logic step;
        logic finish;
        logic pos_done;
    } dp_cmd_t;

    typedef struct packed {
        req_t op;
        logic full;
        logic scan_done;
        logic drop;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/tphq_ctrl.sv
// request sequencer of the timed packet hold queue
module tphq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  tphq_pkg::dp_status_t st,
    output tphq_pkg::dp_cmd_t    cmd
);

    tphq_pkg::state_t state_reg;
    tphq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tphq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tphq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = tphq_pkg::S_DISPATCH;
                end
            end
            tphq_pkg::S_DISPATCH: begin
                if (st.op == tphq_pkg::REQ_ENQ) begin
                    state_next = st.full ? tphq_pkg::S_SCAN_RD : tphq_pkg::S_FINISH;
                end else if (st.op inside {tphq_pkg::REQ_DEQ_HEAD, tphq_pkg::REQ_DEQ_DST,
                                           tphq_pkg::REQ_PURGE}) begin
                    state_next = tphq_pkg::S_SCAN_RD;
                end else if (st.op inside {tphq_pkg::REQ_RETRY, tphq_pkg::REQ_PEEK}) begin
                    state_next = tphq_pkg::S_POS_RD;
                end else begin
                    // unused request codes are dropped silently
                    state_next = tphq_pkg::S_IDLE;
                end
            end
            tphq_pkg::S_SCAN_RD: begin
                state_next = st.scan_done ? tphq_pkg::S_FINISH : tphq_pkg::S_SCAN_EV;
            end
            tphq_pkg::S_SCAN_EV: begin
                if (!(st.drop && st.op == tphq_pkg::REQ_PURGE && !st.out_free)) begin
                    state_next = tphq_pkg::S_SCAN_RD;
                end
            end
            tphq_pkg::S_FINISH: begin
                if (st.out_free) begin
                    state_next = tphq_pkg::S_IDLE;
                end
            end
            tphq_pkg::S_POS_RD: begin
                state_next = tphq_pkg::S_POS_EV;
            end
            tphq_pkg::S_POS_EV: begin
                if (st.out_free) begin
                    state_next = tphq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tphq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            tphq_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            tphq_pkg::S_DISPATCH: begin
                if (st.op == tphq_pkg::REQ_ENQ) begin
                    cmd.scan_init   = st.full;
                    cmd.direct_init = !st.full;
                end else if (st.op inside {tphq_pkg::REQ_DEQ_HEAD, tphq_pkg::REQ_DEQ_DST,
                                           tphq_pkg::REQ_PURGE}) begin
                    cmd.scan_init = 1'b1;
                end
            end
            tphq_pkg::S_SCAN_EV: begin
                // a purged entry needs the output register
                cmd.step = !(st.drop && st.op == tphq_pkg::REQ_PURGE && !st.out_free);
            end
            tphq_pkg::S_FINISH: begin
                cmd.finish = st.out_free;
            end
            tphq_pkg::S_POS_EV: begin
                cmd.pos_done = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/tphq_dpath.sv
// entry store, walk pointers and result register of the timed packet hold queue
`include "timed_packet_hold_queue_core_macros.svh"

module tphq_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tphq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               cfg_we,
    input  logic [tphq_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [tphq_pkg::CFG_DW-1:0]        cfg_wdata,
    input  tphq_pkg::dp_cmd_t                  cmd,
    output tphq_pkg::dp_status_t               st,
    input  logic                               m_axis_tready,
    output logic                               m_axis_tvalid,
    output logic [tphq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);

    tphq_pkg::entry_t entry_mem [tphq_pkg::DEPTH];

    logic [tphq_pkg::TIME_W-1:0] hold_to_reg;
    logic [tphq_pkg::TIME_W-1:0] retry_to_reg;

    tphq_pkg::req_t              op_reg;
    logic [tphq_pkg::DST_W-1:0]  dst_reg;
    logic [tphq_pkg::HND_W-1:0]  hnd_reg;
    logic [tphq_pkg::POS_W-1:0]  pos_reg;
    logic [tphq_pkg::TIME_W-1:0] now_reg;

    logic [tphq_pkg::CNT_W-1:0]  fill_reg;
    logic [tphq_pkg::CNT_W-1:0]  r_idx_reg;
    logic [tphq_pkg::CNT_W-1:0]  w_idx_reg;
    logic                        found_reg;
    tphq_pkg::status_t           hold_status_reg;
    logic [tphq_pkg::HND_W-1:0]  hold_handle_reg;
    logic [tphq_pkg::DST_W-1:0]  hold_dst_reg;
    tphq_pkg::entry_t            rd_data_reg;

    logic                        m_valid_reg;
    tphq_pkg::status_t           m_status_reg;
    logic [tphq_pkg::HND_W-1:0]  m_handle_reg;
    logic [tphq_pkg::DST_W-1:0]  m_dst_reg;
    logic                        m_last_reg;

    logic                        out_free;
    logic                        expired;
    logic                        due;
    logic                        drop;
    logic                        pos_bad;
    logic                        is_pos_op;
    logic [tphq_pkg::IDX_W-1:0]  pos_idx;
    logic [tphq_pkg::IDX_W-1:0]  rd_addr;
    logic [tphq_pkg::TIME_W-1:0] new_retry;

    logic                        wr_en;
    logic [tphq_pkg::IDX_W-1:0]  wr_addr;
    tphq_pkg::entry_t            wr_data;

    logic                        out_load;
    tphq_pkg::status_t           out_status;
    logic [tphq_pkg::HND_W-1:0]  out_handle;
    logic [tphq_pkg::DST_W-1:0]  out_dst;
    logic                        out_last;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign expired   = rd_data_reg.expiry <= now_reg;
    assign due       = rd_data_reg.retry_due <= now_reg;
    assign pos_bad   = tphq_pkg::CMP_W'(pos_reg) >= tphq_pkg::CMP_W'(fill_reg);
    assign is_pos_op = (op_reg == tphq_pkg::REQ_RETRY) || (op_reg == tphq_pkg::REQ_PEEK);
    assign pos_idx   = tphq_pkg::IDX_W'(pos_reg);
    assign rd_addr   = is_pos_op ? pos_idx : r_idx_reg[tphq_pkg::IDX_W-1:0];
    assign new_retry = now_reg + retry_to_reg;

    // entries leaving the queue during a walk
    always_comb begin
        case (op_reg)
            tphq_pkg::REQ_ENQ:      drop = (r_idx_reg == '0);
            tphq_pkg::REQ_DEQ_HEAD: drop = (r_idx_reg == '0);
            tphq_pkg::REQ_DEQ_DST:  drop = !found_reg && (rd_data_reg.dst == dst_reg);
            tphq_pkg::REQ_PURGE:    drop = expired;
            default:                drop = 1'b0;
        endcase
    end

    assign st.op        = op_reg;
    assign st.full      = (fill_reg == tphq_pkg::FULL_CNT);
    assign st.scan_done = (r_idx_reg == fill_reg);
    assign st.drop      = drop;
    assign st.out_free  = out_free;

    // single write port of the entry store
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = w_idx_reg[tphq_pkg::IDX_W-1:0];
        wr_data = rd_data_reg;
        if (cmd.step && !drop) begin
            wr_en = 1'b1;
        end else if (cmd.finish && op_reg == tphq_pkg::REQ_ENQ) begin
            wr_en             = 1'b1;
            wr_data.dst       = dst_reg;
            wr_data.handle    = hnd_reg;
            wr_data.expiry    = now_reg + hold_to_reg;
            wr_data.retry_due = new_retry;
        end else if (cmd.pos_done && op_reg == tphq_pkg::REQ_RETRY && !pos_bad && due) begin
            wr_en             = 1'b1;
            wr_addr           = pos_idx;
            wr_data.retry_due = new_retry;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // result register load
    always_comb begin
        out_load   = 1'b0;
        out_status = tphq_pkg::ST_ENQUEUED;
        out_handle = '0;
        out_dst    = '0;
        out_last   = 1'b1;
        if (cmd.step && drop && op_reg == tphq_pkg::REQ_PURGE) begin
            out_load   = 1'b1;
            out_status = tphq_pkg::ST_PURGED;
            out_handle = rd_data_reg.handle;
            out_dst    = rd_data_reg.dst;
            out_last   = 1'b0;
        end else if (cmd.finish) begin
            out_load = 1'b1;
            if (op_reg == tphq_pkg::REQ_PURGE) begin
                out_status = tphq_pkg::ST_PURGE_DONE;
            end else begin
                out_status = hold_status_reg;
                out_handle = hold_handle_reg;
                out_dst    = hold_dst_reg;
            end
        end else if (cmd.pos_done) begin
            out_load = 1'b1;
            if (pos_bad) begin
                out_status = tphq_pkg::ST_BAD_POS;
            end else begin
                out_handle = rd_data_reg.handle;
                out_dst    = rd_data_reg.dst;
                if (op_reg == tphq_pkg::REQ_PEEK) begin
                    out_status = tphq_pkg::ST_PEEKED;
                end else begin
                    out_status = due ? tphq_pkg::ST_RENEWED : tphq_pkg::ST_NOT_DUE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_to_reg  <= tphq_pkg::HOLD_TIMEOUT_RST;
            retry_to_reg <= tphq_pkg::RETRY_TIMEOUT_RST;
        end else if (cfg_we) begin
            if (cfg_addr == tphq_pkg::CFG_HOLD_TIMEOUT) begin
                hold_to_reg <= cfg_wdata;
            end
            if (cfg_addr == tphq_pkg::CFG_RETRY_TIMEOUT) begin
                retry_to_reg <= cfg_wdata;
            end
        end
    end

    // request capture, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= tphq_pkg::req_t'(s_axis_tdata[tphq_pkg::IN_REQ_LSB +: tphq_pkg::REQ_W]);
            dst_reg <= s_axis_tdata[tphq_pkg::IN_DST_LSB +: tphq_pkg::DST_W];
            hnd_reg <= s_axis_tdata[tphq_pkg::IN_HND_LSB +: tphq_pkg::HND_W];
            pos_reg <= s_axis_tdata[tphq_pkg::IN_POS_LSB +: tphq_pkg::POS_W];
            now_reg <= s_axis_tdata[tphq_pkg::IN_NOW_LSB +: tphq_pkg::TIME_W];
        end
    end

    // walk pointers: r reads every entry, w packs the survivors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            r_idx_reg <= '0;
            w_idx_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                r_idx_reg <= '0;
                w_idx_reg <= '0;
                found_reg <= 1'b0;
            end else if (cmd.direct_init) begin
                w_idx_reg <= fill_reg;
            end else if (cmd.step) begin
                r_idx_reg <= r_idx_reg + 1'b1;
                if (!drop) begin
                    w_idx_reg <= w_idx_reg + 1'b1;
                end else if (op_reg != tphq_pkg::REQ_PURGE) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                fill_reg <= (op_reg == tphq_pkg::REQ_ENQ) ? w_idx_reg + 1'b1 : w_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init || cmd.direct_init) begin
            hold_status_reg <= (op_reg == tphq_pkg::REQ_ENQ) ? tphq_pkg::ST_ENQUEUED
                                                              : tphq_pkg::ST_EMPTY;
            hold_handle_reg <= '0;
            hold_dst_reg    <= '0;
        end else if (cmd.step && drop && op_reg != tphq_pkg::REQ_PURGE) begin
            if (op_reg == tphq_pkg::REQ_ENQ) begin
                hold_status_reg <= expired ? tphq_pkg::ST_DROP_TIMEOUT
                                           : tphq_pkg::ST_DROP_FULL;
            end else begin
                hold_status_reg <= tphq_pkg::ST_DEQUEUED;
            end
            hold_handle_reg <= rd_data_reg.handle;
            hold_dst_reg    <= rd_data_reg.dst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_handle_reg <= out_handle;
            m_dst_reg    <= out_dst;
            m_last_reg   <= out_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{(tphq_pkg::OUT_TDATA_W - tphq_pkg::OUT_W){1'b0}},
                            m_dst_reg, m_handle_reg, m_status_reg};

    `TPHQ_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= tphq_pkg::FULL_CNT)
    `TPHQ_ASSERT_ALWAYS(a_pack_behind_read, aclk, aresetn, w_idx_reg <= r_idx_reg || !cmd.step)
    `TPHQ_ASSERT_IMP(a_load_when_free, aclk, aresetn, out_load, out_free)
    `TPHQ_ASSERT_NEXT(a_enq_not_empty, aclk, aresetn, cmd.finish && (op_reg == tphq_pkg::REQ_ENQ), fill_reg != '0)

endmodule

// File: hw/rtl/timed_packet_hold_queue_core.sv
// top level of the timed packet hold queue
// Holds up to DEPTH packets (handle, destination, expiry, retry due) in age order.
// Input stream s_axis_*: one request per transfer (enqueue, dequeue head, dequeue by
// destination, purge, retry check, peek). Output stream m_axis_*: result transfers,
// m_axis_tlast marks the final result of a request; purge gives one result per
// expired entry and then a done result, codes 6 and 7 give none.
// Configuration: cfg_we/cfg_addr/cfg_wdata write hold_timeout (0) and retry_timeout (1);
// the user writes them only while no request is in flight; the block does not check this.
// One request at a time: s_axis_tready is high only while the sequencer is idle.
// From acceptance to the loading of the result: a non-full enqueue passes dispatch and
// finish, retry check and peek pass dispatch, position read and evaluate; a full enqueue,
// both dequeues and purge walk the entry store with a read and an evaluate step per valid
// entry, then finish. The single-port-read entry memory sets these walk steps.
// A result sits in the output register until taken; while it is stalled the walk
// pauses at the next result that needs the register, the queue state stays intact.
// Reset (aresetn low, synchronous) empties the queue and restores both timeouts;
// entry contents are not cleared.
module timed_packet_hold_queue_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // req_type[2:0], dst_address[34:3], packet_handle[50:35], position[55:51], now[87:56]
    input  logic [tphq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // status[3:0], result_handle[19:4], result_dst[51:20], zero pad
    output logic [tphq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_we,
    input  logic [tphq_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [tphq_pkg::CFG_DW-1:0]        cfg_wdata
);

    tphq_pkg::dp_cmd_t    cmd;
    tphq_pkg::dp_status_t st;

    tphq_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    tphq_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .st            (st),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
